// ----- hdl/urtf_pkg.sv -----
`timescale 1ns / 1ps

package urtf_pkg;

    localparam int OPC_W  = 2;
    localparam int OFS_W  = 8;
    localparam int DAT_W  = 32;
    localparam int BYTE_W = 8;
    localparam int DR_W   = 9;

    localparam int IN_TDATA_W = OFS_W + DAT_W;

    localparam int OUT_ERR_POS  = DAT_W;
    localparam int OUT_BYTE_POS = DAT_W + 1;
    localparam int OUT_LVL_POS  = DAT_W + 1 + BYTE_W;

    localparam int TX_DEPTH_DEF = 16;

    localparam logic [OPC_W-1:0] OP_READ  = 2'd0;
    localparam logic [OPC_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OPC_W-1:0] OP_POP   = 2'd2;
    localparam logic [OPC_W-1:0] OP_RSVD  = 2'd3;

    localparam logic [OFS_W-1:0] SR_ADDR  = 8'd0;
    localparam logic [OFS_W-1:0] DR_ADDR  = 8'd4;
    localparam logic [OFS_W-1:0] BRR_ADDR = 8'd8;
    localparam logic [OFS_W-1:0] CR1_ADDR = 8'd12;

    localparam int SR_RXNE_BIT    = 5;
    localparam int SR_TXE_BIT     = 7;
    localparam int CR1_UE_BIT     = 13;
    localparam int CR1_TE_BIT     = 3;
    localparam int CR1_RE_BIT     = 2;
    localparam int CR1_RXNEIE_BIT = 5;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] data;
    } t_fifo_req;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [BYTE_W-1:0] head_byte;
    } t_fifo_sts;

endpackage

// ----- hdl/urtf_ram.sv -----
`timescale 1ns / 1ps

module urtf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/urtf_fifo.sv -----
`timescale 1ns / 1ps

module urtf_fifo import urtf_pkg::*; #(
    parameter int TX_DEPTH = TX_DEPTH_DEF,
    parameter int LVL_W    = $clog2(TX_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_fifo_req        i_req,
    output t_fifo_sts        o_sts,
    output logic [LVL_W-1:0] o_level_next
);

    localparam int PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TX_DEPTH - 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(TX_DEPTH);

    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [LVL_W-1:0]  r_count, n_count;
    logic              r_byp, n_byp;
    logic [BYTE_W-1:0] r_byp_data;
    logic [BYTE_W-1:0] ram_rdata;
    logic              we;
    logic              re;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign we = i_fire && i_req.push;
    assign re = i_fire && i_req.pop;

    always_comb begin
        n_head  = re ? ptr_inc(r_head) : r_head;
        n_tail  = we ? ptr_inc(r_tail) : r_tail;
        n_count = r_count;
        if (we) begin
            n_count = r_count + LVL_W'(1);
        end else if (re) begin
            n_count = r_count - LVL_W'(1);
        end
        n_byp = we && (r_tail == n_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_byp   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_byp   <= n_byp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= i_req.data;
    end

    urtf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TX_DEPTH),
        .ADDR_W(PTR_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_tail),
        .i_wdata(i_req.data),
        .i_raddr(n_head),
        .o_rdata(ram_rdata)
    );

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count == LVL_FULL);
    assign o_sts.head_byte = r_byp ? r_byp_data : ram_rdata;
    assign o_level_next    = n_count;

endmodule

// ----- hdl/urtf_regs.sv -----
`timescale 1ns / 1ps

module urtf_regs import urtf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [OPC_W-1:0]  i_opcode,
    input  logic [OFS_W-1:0]  i_offset,
    input  logic [DAT_W-1:0]  i_wdata,
    input  t_fifo_sts         i_fifo_sts,
    output t_fifo_req         o_fifo_req,
    output logic [DAT_W-1:0]  o_read_data,
    output logic              o_error,
    output logic [BYTE_W-1:0] o_tx_byte
);

    logic             r_rxne, n_rxne;
    logic [DR_W-1:0]  r_dr, n_dr;
    logic [DAT_W-1:0] r_brr, n_brr;
    logic [3:0]       r_cr1, n_cr1;

    always_comb begin
        logic [DAT_W-1:0] sr_val;
        logic [DAT_W-1:0] cr1_val;
        logic             tx_en;

        sr_val                 = '0;
        sr_val[SR_TXE_BIT]     = 1'b1;
        sr_val[SR_RXNE_BIT]    = r_rxne;
        cr1_val                = '0;
        cr1_val[CR1_UE_BIT]    = r_cr1[3];
        cr1_val[CR1_TE_BIT]    = r_cr1[2];
        cr1_val[CR1_RE_BIT]    = r_cr1[1];
        cr1_val[CR1_RXNEIE_BIT] = r_cr1[0];
        tx_en                  = r_cr1[3] && r_cr1[2];

        n_rxne      = r_rxne;
        n_dr        = r_dr;
        n_brr       = r_brr;
        n_cr1       = r_cr1;
        o_fifo_req  = '0;
        o_read_data = '0;
        o_error     = 1'b0;
        o_tx_byte   = '0;

        unique case (i_opcode)
            OP_READ: begin
                priority if (i_offset == SR_ADDR) begin
                    o_read_data = sr_val;
                end else if (i_offset == DR_ADDR) begin
                    o_read_data = {{(DAT_W - DR_W){1'b0}}, r_dr};
                end else if (i_offset == BRR_ADDR) begin
                    o_read_data = r_brr;
                end else if (i_offset == CR1_ADDR) begin
                    o_read_data = cr1_val;
                end else begin
                    o_error = 1'b1;
                end
            end
            OP_WRITE: begin
                priority if (i_offset == SR_ADDR) begin
                    n_rxne = i_wdata[SR_RXNE_BIT];
                end else if (i_offset == DR_ADDR) begin
                    n_dr = i_wdata[DR_W-1:0];
                    if (tx_en) begin
                        if (i_fifo_sts.full) begin
                            o_error = 1'b1;
                        end else begin
                            o_fifo_req.push = 1'b1;
                            o_fifo_req.data = i_wdata[BYTE_W-1:0];
                        end
                    end
                end else if (i_offset == BRR_ADDR) begin
                    n_brr = i_wdata;
                end else if (i_offset == CR1_ADDR) begin
                    n_cr1 = {i_wdata[CR1_UE_BIT], i_wdata[CR1_TE_BIT],
                             i_wdata[CR1_RE_BIT], i_wdata[CR1_RXNEIE_BIT]};
                end else begin
                    o_error = 1'b1;
                end
            end
            OP_POP: begin
                if (i_fifo_sts.empty) begin
                    o_error = 1'b1;
                end else begin
                    o_fifo_req.pop = 1'b1;
                    o_tx_byte      = i_fifo_sts.head_byte;
                end
            end
            OP_RSVD: begin
                o_error = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rxne <= 1'b0;
            r_dr   <= '0;
            r_brr  <= '0;
            r_cr1  <= '0;
        end else if (i_fire) begin
            r_rxne <= n_rxne;
            r_dr   <= n_dr;
            r_brr  <= n_brr;
            r_cr1  <= n_cr1;
        end
    end

endmodule

// ----- hdl/uart_register_file_tx_fifo.sv -----
`timescale 1ns / 1ps

// UART register file with a transmit FIFO.
// Slave stream: one transaction per operation. tuser carries the opcode
// (read, write, pop); tdata carries the register offset and the write word.
// Master stream: one transaction per operation with the read word, the error
// flag, the popped byte and the FIFO level after the operation.
// An operation lands in an input register, is decoded and applied to the
// registers and FIFO pointers as it leaves that register, and its result is
// held in an output register that drives tvalid.
// Throughput is one operation per cycle while the master side takes each
// result; the FIFO RAM reads the next head address every cycle, so a pop
// finds its byte ready without waiting.
// Reset clears SR (TXE stays set), DR, BRR, CR1 and the FIFO pointers and
// level, and drops both valid flags. FIFO contents are not cleared.
// When the master side stalls, the result stays in the output register and
// the input register still takes one more operation; after that s_axis_tready
// falls until the result is taken.

module uart_register_file_tx_fifo import urtf_pkg::*; #(
    parameter int TX_DEPTH = TX_DEPTH_DEF,
    parameter int LVL_W    = $clog2(TX_DEPTH + 1),
    parameter int OUT_W    = ((OUT_LVL_POS + LVL_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // reg_offset[7:0], write_data[39:8]
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [OPC_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_data[31:0], error[32], tx_byte[40:33], tx_level above, zero pad
    output logic [OUT_W-1:0]      m_axis_tdata
);

    logic              r_in_valid;
    logic [OPC_W-1:0]  r_opcode;
    logic [OFS_W-1:0]  r_offset;
    logic [DAT_W-1:0]  r_wdata;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data, n_out_data;
    logic              fire;
    logic              in_take;
    t_fifo_req         fifo_req;
    t_fifo_sts         fifo_sts;
    logic [LVL_W-1:0]  level_next;
    logic [DAT_W-1:0]  read_data;
    logic              error;
    logic [BYTE_W-1:0] tx_byte;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_opcode <= s_axis_tuser;
            r_offset <= s_axis_tdata[OFS_W-1:0];
            r_wdata  <= s_axis_tdata[OFS_W +: DAT_W];
        end
        if (fire) begin
            r_out_data <= n_out_data;
        end
    end

    urtf_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_opcode   (r_opcode),
        .i_offset   (r_offset),
        .i_wdata    (r_wdata),
        .i_fifo_sts (fifo_sts),
        .o_fifo_req (fifo_req),
        .o_read_data(read_data),
        .o_error    (error),
        .o_tx_byte  (tx_byte)
    );

    urtf_fifo #(
        .TX_DEPTH(TX_DEPTH),
        .LVL_W   (LVL_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_req       (fifo_req),
        .o_sts       (fifo_sts),
        .o_level_next(level_next)
    );

    always_comb begin
        n_out_data                           = '0;
        n_out_data[DAT_W-1:0]                = read_data;
        n_out_data[OUT_ERR_POS]              = error;
        n_out_data[OUT_BYTE_POS +: BYTE_W]   = tx_byte;
        n_out_data[OUT_LVL_POS +: LVL_W]     = level_next;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- hdl/urtf_checker.sv -----
`timescale 1ns / 1ps

module urtf_checker import urtf_pkg::*; #(
    parameter int TX_DEPTH = TX_DEPTH_DEF,
    parameter int LVL_W    = $clog2(TX_DEPTH + 1),
    parameter int OUT_W    = ((OUT_LVL_POS + LVL_W + 7) / 8) * 8
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_TDATA_W-1:0] s_axis_tdata,
    input logic [OPC_W-1:0]      s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_W-1:0]      m_axis_tdata
);

    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(TX_DEPTH);

    logic             out_err;
    logic [LVL_W-1:0] out_lvl;

    assign out_err = m_axis_tdata[OUT_ERR_POS];
    assign out_lvl = m_axis_tdata[OUT_LVL_POS +: LVL_W];

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> out_lvl <= LVL_FULL)
        else $error("FIFO level above depth");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_err |->
            m_axis_tdata[DAT_W-1:0] == '0 && m_axis_tdata[OUT_BYTE_POS +: BYTE_W] == '0)
        else $error("error result carries data");

    a_level_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && out_lvl == '0 && !s_axis_tvalid
            && !$past(s_axis_tvalid) |=> !m_axis_tvalid || out_lvl <= LVL_W'(1))
        else $error("FIFO level jumped by more than one");

endmodule

bind uart_register_file_tx_fifo urtf_checker #(
    .TX_DEPTH(TX_DEPTH),
    .LVL_W   (LVL_W),
    .OUT_W   (OUT_W)
) u_urtf_checker (.*);
